[rtl/psvg_pkg.sv]
// shared types, constants and helper functions of the polygon and star vertex generator
`default_nettype none
package psvg_pkg;

  localparam int MAX_VERTICES_DEF = 63;
  localparam int CORDIC_STEPS     = 24;
  localparam int CW               = 34;  // cordic x, y, z width
  localparam logic [15:0] RATIO_LOW  = 16'd3277;
  localparam logic [15:0] RATIO_HIGH = 16'd62259;
  localparam logic signed [CW-1:0] GAIN_INV = 34'sh026DD3B6A;

  typedef enum logic [1:0] {
    CMD_MOVE  = 2'd0,
    CMD_LINE  = 2'd1,
    CMD_CLOSE = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_X,
    S_SCALE_Y,
    S_SCALE_END,
    S_DIV,
    S_TRIG,
    S_MUL_X,
    S_MUL_Y,
    S_EMIT,
    S_CLOSE
  } state_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sh020000000;
      5'd1:  v = 34'sh012E4051E;
      5'd2:  v = 34'sh009FB385B;
      5'd3:  v = 34'sh0051111D4;
      5'd4:  v = 34'sh0028B0D43;
      5'd5:  v = 34'sh00145D7E1;
      5'd6:  v = 34'sh000A2F61E;
      5'd7:  v = 34'sh000517C55;
      5'd8:  v = 34'sh00028BE53;
      5'd9:  v = 34'sh000145F2F;
      5'd10: v = 34'sh0000A2F98;
      5'd11: v = 34'sh0000517CC;
      5'd12: v = 34'sh000028BE6;
      5'd13: v = 34'sh0000145F3;
      5'd14: v = 34'sh00000A2FA;
      5'd15: v = 34'sh00000517D;
      5'd16: v = 34'sh0000028BE;
      5'd17: v = 34'sh00000145F;
      5'd18: v = 34'sh000000A30;
      5'd19: v = 34'sh000000518;
      5'd20: v = 34'sh00000028C;
      5'd21: v = 34'sh000000146;
      5'd22: v = 34'sh0000000A3;
      5'd23: v = 34'sh000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // saturate a 39 bit signed sum to 32 bits
  function automatic logic [31:0] sat32(input logic signed [38:0] v);
    logic [31:0] r;
    if (v > 39'sh07FFFFFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -39'sh080000000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/psvg_cordic.sv]
// iterative cordic rotation giving cosine and sine of a phase in 2^-32 turn units
`default_nettype none
module psvg_cordic (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        go,
  input  wire logic [31:0]                 phase,
  output logic                             done,
  output logic signed [psvg_pkg::CW:0]     cos_v,
  output logic signed [psvg_pkg::CW:0]     sin_v
);
  import psvg_pkg::*;

  logic signed [CW-1:0] x, y, z;
  logic [1:0]           q;
  logic [4:0]           i;
  logic                 running;
  logic [1:0]           q_in;
  logic [31:0]          z_in;
  logic signed [CW-1:0] dx, dy;

  assign q_in = 2'((phase + 32'h2000_0000) >> 30);
  assign z_in = phase - {q_in, 30'b0};
  assign dx   = y >>> i;
  assign dy   = x >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        x <= GAIN_INV;
        y <= '0;
        z <= CW'(signed'(z_in));
        q <= q_in;
        i <= '0;
      end else if (running) begin
        if (!z[CW-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_turn(i);
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_turn(i);
        end
        i <= i + 5'd1;
        if (i == 5'(CORDIC_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // quarter turn applied by swaps and negations
  always_comb begin
    case (q)
      2'd0: begin cos_v = (CW+1)'(x);  sin_v = (CW+1)'(y);  end
      2'd1: begin cos_v = -(CW+1)'(y); sin_v = (CW+1)'(x);  end
      2'd2: begin cos_v = -(CW+1)'(x); sin_v = -(CW+1)'(y); end
      default: begin cos_v = (CW+1)'(y); sin_v = -(CW+1)'(x); end
    endcase
  end

  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("cordic done while still running");
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    go |=> running) else $error("cordic did not start");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("cordic done longer than one cycle");

endmodule
`default_nettype wire

[rtl/polygon_star_vertex_generator_core.sv]
// top level: regular polygon and star outline generator with a shared multiplier and cordic
// a request gives m vertex items and then a close item, m up to MAX_VERTICES
// each vertex costs a 32 step bit-serial phase divide, a 24 step cordic and 2 multiplies
// one request at a time: busy stays high until the close item has been issued
// results appear for one cycle with strobe high; the receiver cannot stall
// reset (rst, synchronous, active high) returns to idle with no strobe
`default_nettype none
module polygon_star_vertex_generator_core #(
  parameter int MAX_VERTICES = psvg_pkg::MAX_VERTICES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] center_x,
  input  wire logic [31:0] center_y,
  input  wire logic [31:0] half_width,
  input  wire logic [31:0] half_height,
  input  wire logic [5:0]  point_count,
  input  wire logic        star_mode,
  input  wire logic [15:0] inner_ratio,
  output logic             strobe,
  output logic [1:0]       command,
  output logic [31:0]      vertex_x,
  output logic [31:0]      vertex_y,
  output logic             last
);
  import psvg_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES + 1);

  state_t state, state_next;

  // request registers
  logic signed [31:0] cx, cy, hw, hh, irx, iry;
  logic [15:0]        ratio;
  logic               star;
  logic [VW-1:0]      m, k;

  // phase divider
  logic [VW-1:0] rem;
  logic [31:0]   lo, quot, quot_next;
  logic [4:0]    jcnt;
  logic [VW:0]   r2;
  logic          qbit;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [67:0] prod, prod_rnd;
  logic [31:0]        vx;

  // trig
  logic                 trig_go, trig_done;
  logic signed [CW:0]   cos_v, sin_v;

  // request decode
  logic [6:0]    cnt_lo, limit, cnt;
  logic [VW-1:0] m_in;
  logic [15:0]   ratio_in;

  always_comb begin
    limit  = star_mode ? 7'(MAX_VERTICES / 2) : 7'(MAX_VERTICES);
    cnt_lo = (point_count < 6'd3) ? 7'd3 : {1'b0, point_count};
    cnt    = (cnt_lo > limit) ? limit : cnt_lo;
    m_in   = star_mode ? VW'({cnt, 1'b0}) : VW'(cnt);
    if (inner_ratio < RATIO_LOW) begin
      ratio_in = RATIO_LOW;
    end else if (inner_ratio > RATIO_HIGH) begin
      ratio_in = RATIO_HIGH;
    end else begin
      ratio_in = inner_ratio;
    end
  end

  // one restoring step of k * 2^32 + m/2 over m
  assign r2        = {rem, lo[31]};
  assign qbit      = (r2 >= {1'b0, m});
  assign quot_next = {quot[30:0], qbit};
  assign trig_go   = (state == S_DIV) && (jcnt == 5'd31);

  psvg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .go    (trig_go),
    .phase (quot_next),
    .done  (trig_done),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  // multiplier operand select; the star's odd vertices use the inner radii
  always_comb begin
    mul_a = hw;
    mul_b = 36'(signed'({1'b0, ratio}));
    case (state)
      S_SCALE_Y: begin
        mul_a = hh;
      end
      S_MUL_X: begin
        mul_a = (star && k[0]) ? irx : hw;
        mul_b = 36'(sin_v);
      end
      S_MUL_Y: begin
        mul_a = (star && k[0]) ? iry : hh;
        mul_b = -36'(cos_v);
      end
      default: ;
    endcase
  end

  assign prod_rnd = prod + 68'sd536870912;  // half of 2^30

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (start) state_next = S_SCALE_X;
      S_SCALE_X:   state_next = S_SCALE_Y;
      S_SCALE_Y:   state_next = S_SCALE_END;
      S_SCALE_END: state_next = S_DIV;
      S_DIV:       if (jcnt == 5'd31) state_next = S_TRIG;
      S_TRIG:      if (trig_done) state_next = S_MUL_X;
      S_MUL_X:     state_next = S_MUL_Y;
      S_MUL_Y:     state_next = S_EMIT;
      S_EMIT:      state_next = (k == m - VW'(1)) ? S_CLOSE : S_DIV;
      S_CLOSE:     state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (state == S_EMIT) || (state == S_CLOSE);
    end
    case (state)
      S_IDLE: begin
        cx    <= center_x;
        cy    <= center_y;
        hw    <= half_width;
        hh    <= half_height;
        star  <= star_mode;
        m     <= m_in;
        ratio <= ratio_in;
      end
      S_SCALE_X: begin
        prod <= mul_a * mul_b;
      end
      S_SCALE_Y: begin
        irx  <= 32'((prod + 68'sd32768) >>> 16);
        prod <= mul_a * mul_b;
      end
      S_SCALE_END: begin
        iry  <= 32'((prod + 68'sd32768) >>> 16);
        k    <= '0;
        rem  <= '0;
        lo   <= 32'(m >> 1);
        jcnt <= '0;
      end
      S_DIV: begin
        rem  <= qbit ? VW'(r2 - {1'b0, m}) : VW'(r2);
        lo   <= {lo[30:0], 1'b0};
        quot <= quot_next;
        jcnt <= jcnt + 5'd1;
      end
      S_MUL_X: begin
        prod <= mul_a * mul_b;
      end
      S_MUL_Y: begin
        vx   <= sat32(39'(cx) + 39'(signed'(prod_rnd[67:30])));
        prod <= mul_a * mul_b;
      end
      S_EMIT: begin
        command  <= (k == '0) ? CMD_MOVE : CMD_LINE;
        vertex_x <= vx;
        vertex_y <= sat32(39'(cy) + 39'(signed'(prod_rnd[67:30])));
        last     <= 1'b0;
        k        <= k + VW'(1);
        rem      <= k + VW'(1);
        lo       <= 32'(m >> 1);
        jcnt     <= '0;
      end
      S_CLOSE: begin
        command  <= CMD_CLOSE;
        vertex_x <= '0;
        vertex_y <= '0;
        last     <= 1'b1;
      end
      default: ;
    endcase
  end

  // close item carries zero coordinates and last
  a_close_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> command == CMD_CLOSE && vertex_x == '0 && vertex_y == '0)
    else $error("close item malformed");
  // accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request not taken");
  // no vertex item once idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !busy && !$past(busy) |-> !strobe) else $error("item while idle");
  // last only on a strobed close
  a_last_close: assert property (@(posedge clk) disable iff (rst)
    strobe && command != CMD_CLOSE |-> !last) else $error("last on vertex item");

endmodule
`default_nettype wire
